// ----- design/sfe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types, constants and the 6-bit packing function of the frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

  localparam int JOB_BYTES = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TX_DELAY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COMMAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER    = 2'd2;

  // pack phases
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;

  localparam logic [7:0] CKSUM_BASE = 8'hff;

  // all result bytes of one accepted item
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
  } job_t;

  typedef struct packed {
    logic       two;      // c1 is also emitted
    logic [7:0] c0;
    logic [7:0] c1;
    logic [1:0] phase;
    logic [5:0] partial;
  } pack_t;

  typedef struct packed {
    logic [7:0] tx_delay;
    logic [7:0] start_command;
    logic [7:0] end_marker;
  } cfg_t;

  function automatic pack_t pack_byte(input logic [1:0] phase, input logic [5:0] partial,
                                      input logic [7:0] b);
    pack_t r;
    r = '0;
    case (phase)
      PH_1: begin
        r.c0      = {2'b00, partial | {2'b00, b[3:0]}};
        r.partial = {b[7:4], 2'b00};
        r.phase   = PH_2;
      end
      PH_2: begin
        r.c0      = {2'b00, partial | {4'b0000, b[1:0]}};
        r.c1      = {2'b00, b[7:2]};
        r.two     = 1'b1;
        r.partial = 6'd0;
        r.phase   = PH_0;
      end
      default: begin
        // phase three cannot arise; same as phase zero
        r.c0      = {2'b00, b[5:0]};
        r.partial = {b[7:6], 4'b0000};
        r.phase   = PH_1;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/sfe_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_front
// Accepts frame bytes, tracks pack phase and checksum, builds the byte job.
// ----------------------------------------------------------------------------
module sfe_front
  import sfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_first_of_frame,
  input  wire logic       in_last_of_frame,
  input  wire logic       q_full,
  output logic            q_push,
  output job_t            q_job
);

  logic [1:0] phase_r, phase_nxt;
  logic [5:0] partial_r, partial_nxt;
  logic [7:0] sum_r, sum_nxt;

  logic [7:0] b;
  logic [2:0] n;
  pack_t      pr;
  job_t       job;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;
  assign q_job    = job;

  always_comb begin
    b           = in_data_byte;
    phase_nxt   = phase_r;
    partial_nxt = partial_r;
    sum_nxt     = sum_r;
    job         = '0;
    n           = 3'd0;

    if (in_first_of_frame) begin
      phase_nxt    = PH_0;
      partial_nxt  = 6'd0;
      sum_nxt      = 8'd0;
      job.bytes[0] = cfg.start_command;
      job.bytes[1] = cfg.end_marker;
      n            = 3'd2;
      b            = cfg.tx_delay;
    end

    sum_nxt = sum_nxt + b;
    pr = pack_byte(phase_nxt, partial_nxt, b);
    job.bytes[n] = pr.c0;
    n = n + 3'd1;
    if (pr.two) begin
      job.bytes[n] = pr.c1;
      n = n + 3'd1;
    end
    phase_nxt   = pr.phase;
    partial_nxt = pr.partial;

    if (in_last_of_frame) begin
      pr = pack_byte(phase_nxt, partial_nxt, CKSUM_BASE - sum_nxt);
      job.bytes[n] = pr.c0;
      n = n + 3'd1;
      if (pr.two) begin
        job.bytes[n] = pr.c1;
        n = n + 3'd1;
      end
      // flush pending character
      if (pr.phase != PH_0) begin
        job.bytes[n] = {2'b00, pr.partial};
        n = n + 3'd1;
      end
      job.bytes[n] = cfg.end_marker;
      n = n + 3'd1;
      phase_nxt   = PH_0;
      partial_nxt = 6'd0;
      sum_nxt     = 8'd0;
    end

    job.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_0;
      partial_r <= 6'd0;
      sum_r     <= 8'd0;
    end else if (q_push) begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      sum_r     <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/sfe_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module sfe_queue
  import sfe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output job_t      q_job
);

  job_t       mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_job   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/sfe_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfe_back
// Plays out the bytes of each job, one beat per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sfe_back
  import sfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire job_t       q_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);

  job_t       cur_r;
  logic       cur_valid_r;
  logic [2:0] idx_r;
  logic       beat;
  logic       done;

  assign out_valid    = cur_valid_r;
  assign out_byte     = cur_r.bytes[idx_r];
  assign out_run_last = (idx_r == cur_r.cnt - 3'd1);
  assign beat         = cur_valid_r & ~out_stall;
  assign done         = beat & out_run_last;
  assign pop          = q_valid & (~cur_valid_r | done);

  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 3'd0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (beat) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> idx_r < cur_r.cnt)
    else $error("byte index past end of job");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.cnt != 3'd0 && cur_r.cnt <= 3'd6))
    else $error("job byte count out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && out_stall |=> cur_valid_r && $stable(idx_r))
    else $error("job advanced while stalled");

endmodule
`default_nettype wire

// ----- design/sixpack_frame_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sixpack_frame_encoder
// 6PACK transmit-frame encoder: markers, 6-bit packing, checksum and flush.
// ----------------------------------------------------------------------------
// An input byte is taken in the cycle it arrives whenever the two-entry job
// queue has room, so bytes may follow back to back. Each byte yields one to six
// line bytes (one or two for a data byte, start and end marker added at frame
// start, checksum, flush and end marker at frame end); the output stage sends
// one line byte per cycle while out_stall is low, and a frame yields about 1.33
// line bytes per data byte. The first result of an item passes through the job
// queue and the output stage's job register before it appears. Configuration
// writes are always ready and take effect on the next accepted byte.
module sixpack_frame_encoder
  import sfe_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_first_of_frame,
  input  wire logic                 in_last_of_frame,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_run_last
);

  cfg_t cfg_r;
  logic q_full, q_push, q_valid, q_pop;
  job_t push_job, head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TX_DELAY:      cfg_r.tx_delay      <= cfg_data;
        CFG_START_COMMAND: cfg_r.start_command <= cfg_data;
        CFG_END_MARKER:    cfg_r.end_marker    <= cfg_data;
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  sfe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_of_frame (in_first_of_frame),
    .in_last_of_frame  (in_last_of_frame),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_job             (push_job)
  );

  sfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (head_job)
  );

  sfe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_job        (head_job),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule
`default_nettype wire

// ----- sim/sixpack_frame_encoder_checker.sv -----
// ----------------------------------------------------------------------------
// sixpack_frame_encoder_checker
// Watches the register, byte and line channels of the frame encoder. For each
// accepted frame byte it works out the line bytes that byte must produce and
// queues them; each accepted line beat is compared against the oldest entry.
// ----------------------------------------------------------------------------
module sixpack_frame_encoder_checker
  import sfe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_of_frame,
  input  logic                 in_last_of_frame,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_byte,
  input  logic                 out_run_last,
  output int                   mismatches,
  output int                   due_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [7:0] value;
    logic       run_last;
  } line_beat_t;

  line_beat_t line_bytes_due[$];

  cfg_t       regs;
  logic [1:0] grp_phase;
  logic [5:0] carry_char;
  logic [7:0] frame_sum;

  // the newest line byte is held back until we know whether it closes the item
  logic       held_ok;
  logic [7:0] held_byte;

  function automatic void queue_char(input logic [7:0] v);
    line_beat_t lb;
    if (held_ok) begin
      lb.value    = held_byte;
      lb.run_last = 1'b0;
      line_bytes_due.push_back(lb);
    end
    held_byte = v;
    held_ok   = 1'b1;
  endfunction

  // three bytes go out as four 6-bit characters, low bits first
  function automatic void pack_six(input logic [7:0] b);
    case (grp_phase)
      PH_1: begin
        queue_char({2'b00, carry_char | {2'b00, b[3:0]}});
        carry_char = {b[7:4], 2'b00};
        grp_phase  = PH_2;
      end
      PH_2: begin
        queue_char({2'b00, carry_char | {4'b0000, b[1:0]}});
        queue_char({2'b00, b[7:2]});
        carry_char = '0;
        grp_phase  = PH_0;
      end
      default: begin
        queue_char({2'b00, b[5:0]});
        carry_char = {b[7:6], 4'b0000};
        grp_phase  = PH_1;
      end
    endcase
  endfunction

  function automatic void encode_frame_byte(input logic [7:0] data, input logic first,
                                            input logic last);
    logic [7:0] b;
    line_beat_t lb;
    b = data;
    held_ok = 1'b0;
    if (first) begin
      grp_phase  = PH_0;
      carry_char = '0;
      frame_sum  = '0;
      queue_char(regs.start_command);
      queue_char(regs.end_marker);
      b = regs.tx_delay;
    end
    frame_sum = frame_sum + b;
    pack_six(b);
    if (last) begin
      pack_six(CKSUM_BASE - frame_sum);
      if (grp_phase != PH_0)
        queue_char({2'b00, carry_char});
      queue_char(regs.end_marker);
      grp_phase  = PH_0;
      carry_char = '0;
      frame_sum  = '0;
    end
    lb.value    = held_byte;
    lb.run_last = 1'b1;
    line_bytes_due.push_back(lb);
  endfunction

  always @(posedge clk) begin
    line_beat_t want;
    if (!rst_n) begin
      regs       = '0;
      grp_phase  = PH_0;
      carry_char = '0;
      frame_sum  = '0;
      held_ok    = 1'b0;
      held_byte  = '0;
      line_bytes_due.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TX_DELAY:      regs.tx_delay      = cfg_data;
          CFG_START_COMMAND: regs.start_command = cfg_data;
          CFG_END_MARKER:    regs.end_marker    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        encode_frame_byte(in_data_byte, in_first_of_frame, in_last_of_frame);
      if (out_valid && !out_stall) begin
        if (line_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: unexpected line beat byte=%02h last=%0b",
                     $time, out_byte, out_run_last);
        end else begin
          want = line_bytes_due.pop_front();
          if (out_byte !== want.value || out_run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: line beat mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                       $time, want.value, out_byte, want.run_last, out_run_last);
          end
        end
      end
    end
    due_count = line_bytes_due.size();
  end

endmodule

// ----- sim/sixpack_frame_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// sixpack_frame_encoder_tb
// Drives register writes and frame bytes into the encoder and throttles the
// line side, under several register settings and idling mixes, including a
// long receiver hold-off; the checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module sixpack_frame_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfe_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 cfg_valid         = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index         = CFG_TX_DELAY;
  logic [7:0]           cfg_data          = '0;
  logic                 in_valid          = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte      = '0;
  logic                 in_first_of_frame = 1'b0;
  logic                 in_last_of_frame  = 1'b0;
  logic                 out_valid;
  logic                 out_stall         = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_run_last;

  int   mismatches;
  int   due_count;
  int   in_gap_pct  = 0;
  int   out_gap_pct = 0;
  logic hold_req    = 1'b0;
  logic hold_taken  = 1'b0;
  int   hold_left   = 0;
  int   quiet       = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sixpack_frame_encoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_of_frame (in_first_of_frame),
    .in_last_of_frame  (in_last_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last)
  );

  sixpack_frame_encoder_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_first_of_frame (in_first_of_frame),
    .in_last_of_frame  (in_last_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .mismatches        (mismatches),
    .due_count         (due_count)
  );

  // line side: one long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [7:0] txd, input logic [7:0] cmd,
                          input logic [7:0] marker);
    write_reg(CFG_TX_DELAY, txd);
    write_reg(CFG_START_COMMAND, cmd);
    write_reg(CFG_END_MARKER, marker);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= b;
    in_first_of_frame <= first;
    in_last_of_frame  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // sender stops until every queued line byte has gone out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // mostly well-formed frames with random content, some loose beats
  task automatic run_traffic(input int n_items);
    int sent;
    int flen;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end else begin
        flen = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 14);
        for (int k = 0; k < flen; k++) begin
          send_byte(8'($urandom_range(255)), k == 0, k == flen - 1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(8'h00, 8'hff, 8'h00);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h5a, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'haa, 1'b0, 1'b0);
    send_byte(8'h3c, 1'b0, 1'b1);
    // restart in mid-frame drops the pending character and sum
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h99, 1'b1, 1'b0);
    send_byte(8'hf0, 1'b0, 1'b1);
    // bytes with no frame open
    send_byte(8'hc3, 1'b0, 1'b0);
    send_byte(8'h81, 1'b0, 1'b0);
    send_byte(8'h7e, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    wait_drained();

    set_regs(8'hff, 8'h00, 8'hff);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    wait_drained();

    set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    in_gap_pct  = 28;
    out_gap_pct <= 87;
    run_traffic(60);
    wait_drained();
    run_traffic(60);
    wait_drained();

    set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    in_gap_pct  = 87;
    out_gap_pct <= 28;
    run_traffic(120);
    wait_drained();

    set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    in_gap_pct  = 0;
    out_gap_pct <= 0;
    hold_req    <= 1'b1;
    run_traffic(120);
    wait_drained();

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && due_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
